// ===== hdl/ohr_pkg.sv =====
// Shared types, constants and helpers for the overwriting history ring.
package ohr_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned ENTRY_BYTES_DEF = 8;
	localparam int unsigned CNT_W = 7;
	localparam int unsigned PADDR_W = 3;
	localparam logic [CNT_W-1:0] RING_DEPTH_RST = 7'd64;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_WRITTEN = 2'd0,
		ST_MORE    = 2'd1,
		ST_LAST    = 2'd2,
		ST_BOUNDS  = 2'd3
	} ohr_status_t;

	typedef struct packed {
		logic        mode;
		logic [63:0] write_data;
		logic [3:0]  write_length;
		logic [5:0]  entry_index;
		logic [3:0]  read_length;
	} ohr_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  next_index;
		logic [63:0] read_data;
		logic [6:0]  fill_count;
	} ohr_out_t;

	typedef struct packed {
		logic [CNT_W-1:0] depth;
		logic             clear;
	} ohr_cfg_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic load;
	} ohr_cell_ctl_t;

	// Mask covering the low n bytes of a 64-bit word.
	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			m[8*b +: 8] = {8{(4'(b) < n)}};
		end
		return m;
	endfunction

endpackage

// ===== hdl/overwriting_history_ring_core.sv =====
// Top level of the overwriting history ring: cell chain, control and result queue.
//
// The ring keeps up to the configured depth of fixed-size entries in a chain of
// cells ordered by age, the oldest at the head. An add finishes when it is
// taken: while the ring has room the new entry lands in the first free cell, and
// once it is full every cell hands its entry to its neighbor toward the head, the
// oldest drops out, and the new bytes are merged over the dropped entry into the
// last active cell, so bytes past the write length keep the contents of the slot
// being reused. A read whose age index is out of bounds also finishes when it is
// taken. A read in bounds rotates the active part of the chain once around, a
// step for each cell of the effective depth (1 to 64 at the default size), and
// holds the input stalled until the rotation ends, so no new beat is taken while
// it runs; the entry is captured as it passes the head, and the chain ends in its
// original order. That rotation through the single head tap sets the read rate.
// Writing the depth register empties the ring and zeroes every cell at that same
// clock edge, so no clearing pass follows. Results go through a two-beat queue,
// so the next input beat is taken while an earlier result is still waiting to be
// taken.
module overwriting_history_ring_core #(
	parameter int unsigned DEPTH       = ohr_pkg::DEPTH_DEF,
	parameter int unsigned ENTRY_BYTES = ohr_pkg::ENTRY_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ohr_pkg::ohr_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output ohr_pkg::ohr_out_t           out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ohr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int unsigned EW = 8 * ENTRY_BYTES;
	localparam int unsigned CW = ohr_pkg::CNT_W;

	typedef enum logic {
		S_IDLE,
		S_ROT
	} state_t;

	ohr_pkg::ohr_cfg_t      cfg;
	ohr_pkg::ohr_cell_ctl_t ctl;

	state_t          state_q;
	logic [CW-1:0]   held_q;
	logic [CW-1:0]   rot_cnt_q;
	logic [5:0]      idx_q;
	logic [EW-1:0]   rmask_q;
	logic [1:0]      stat_q;
	logic [6:0]      next_q;
	logic [EW-1:0]   cap_q;

	logic [CW-1:0]   eff;
	logic            full;
	logic            accept;
	logic            is_add;
	logic            in_bounds;
	logic [3:0]      wlen;
	logic [3:0]      rlen;
	logic [63:0]     wmask_all;
	logic [63:0]     rmask_all;
	logic [EW-1:0]   wmask;
	logic [EW-1:0]   rmask;
	logic [EW-1:0]   head;
	logic [EW-1:0]   tail;
	logic [EW-1:0]   rd_now;
	logic            rot_done;
	logic [6:0]      idx_next;

	logic [EW-1:0]   cell_data [DEPTH];

	ohr_pkg::ohr_out_t res;
	logic              push;
	logic              pop;
	ohr_pkg::ohr_out_t slot0_q;
	ohr_pkg::ohr_out_t slot1_q;
	logic [1:0]        qcnt_q;

	ohr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// The effective depth is the register clamped to at least one entry and at
	// most the number of cells.
	always_comb begin
		if (cfg.depth == '0) begin
			eff = CW'(1);
		end else if (int'(cfg.depth) > int'(DEPTH)) begin
			eff = CW'(DEPTH);
		end else begin
			eff = cfg.depth;
		end
	end

	assign full      = (held_q == eff);
	assign in_stall  = (state_q == S_ROT) || (qcnt_q == 2'd2);
	assign accept    = in_valid && !in_stall;
	assign is_add    = (in_data.mode == ohr_pkg::MODE_ADD);
	assign in_bounds = ({1'b0, in_data.entry_index} < held_q);
	assign idx_next  = {1'b0, in_data.entry_index} + 7'd1;

	// Lengths saturate at the entry size before they become byte masks.
	assign wlen  = (in_data.write_length > 4'(ENTRY_BYTES)) ? 4'(ENTRY_BYTES)
	                                                        : in_data.write_length;
	assign rlen  = (in_data.read_length > 4'(ENTRY_BYTES)) ? 4'(ENTRY_BYTES)
	                                                       : in_data.read_length;
	assign wmask_all = ohr_pkg::byte_mask(wlen);
	assign rmask_all = ohr_pkg::byte_mask(rlen);
	assign wmask     = wmask_all[EW-1:0];
	assign rmask     = rmask_all[EW-1:0];

	assign head = cell_data[0];

	// During a rotation the head wraps around into the last active cell. On an
	// add into a full ring the oldest entry is the slot being reused, so its
	// upper bytes survive; a slot never used since the last clear is all zero.
	always_comb begin
		if (state_q == S_ROT) begin
			tail = head;
		end else begin
			tail = ((full ? head : '0) & ~wmask) | (in_data.write_data[EW-1:0] & wmask);
		end
	end

	assign ctl.clear = cfg.clear;
	assign ctl.shift = (accept && is_add && full) || (state_q == S_ROT);
	assign ctl.load  = accept && is_add && !full;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [EW-1:0] nxt;
		if (i == DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		ohr_cell #(
			.EW(EW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.is_last  (int'(eff) - 1 == i),
			.is_load  (int'(held_q) == i),
			.next_data(nxt),
			.tail_data(tail),
			.data     (cell_data[i])
		);
	end

	// The target entry is at the head after as many rotation steps as its age.
	assign rd_now   = (rot_cnt_q == {1'b0, idx_q}) ? (head & rmask_q) : cap_q;
	assign rot_done = (state_q == S_ROT) && (rot_cnt_q == eff - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rot_cnt_q <= '0;
			held_q    <= '0;
			idx_q     <= '0;
			rmask_q   <= '0;
			stat_q    <= '0;
			next_q    <= '0;
			cap_q     <= '0;
		end else begin
			if (cfg.clear) begin
				held_q <= '0;
			end else if (accept && is_add && !full) begin
				held_q <= held_q + CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept && !is_add && in_bounds) begin
						state_q   <= S_ROT;
						rot_cnt_q <= '0;
						idx_q     <= in_data.entry_index;
						rmask_q   <= rmask;
						if (idx_next < held_q) begin
							stat_q <= ohr_pkg::ST_MORE;
							next_q <= idx_next;
						end else begin
							stat_q <= ohr_pkg::ST_LAST;
							next_q <= '0;
						end
					end
				end
				S_ROT: begin
					cap_q     <= rd_now;
					rot_cnt_q <= rot_cnt_q + CW'(1);
					if (rot_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result for this cycle: adds and out-of-bounds reads finish on acceptance,
	// reads in bounds when the rotation closes.
	always_comb begin
		res  = '0;
		push = 1'b0;
		if (rot_done) begin
			push           = 1'b1;
			res.status     = stat_q;
			res.next_index = next_q;
			res.read_data  = 64'(rd_now);
			res.fill_count = held_q;
		end else if (accept && is_add) begin
			push           = 1'b1;
			res.status     = ohr_pkg::ST_WRITTEN;
			res.fill_count = full ? held_q : held_q + CW'(1);
		end else if (accept && !in_bounds) begin
			push           = 1'b1;
			res.status     = ohr_pkg::ST_BOUNDS;
			res.fill_count = held_q;
		end
	end

	assign out_valid = (qcnt_q != 2'd0);
	assign out_data  = slot0_q;
	assign pop       = out_valid && !out_stall;

	// Two-beat result queue; slot0 is the beat on offer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q  <= '0;
			slot0_q <= '0;
			slot1_q <= '0;
		end else begin
			if (push && pop) begin
				if (qcnt_q == 2'd1) begin
					slot0_q <= res;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= res;
				end
			end else if (pop) begin
				slot0_q <= slot1_q;
				qcnt_q  <= qcnt_q - 2'd1;
			end else if (push) begin
				if (qcnt_q == 2'd0) begin
					slot0_q <= res;
				end else begin
					slot1_q <= res;
				end
				qcnt_q <= qcnt_q + 2'd1;
			end
		end
	end

endmodule

// ===== hdl/ohr_cell.sv =====
// One storage cell of the history chain; holds one entry in age order.
module ohr_cell #(
	parameter int unsigned EW = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ohr_pkg::ohr_cell_ctl_t ctl,
	input  logic                   is_last,
	input  logic                   is_load,
	input  logic [EW-1:0]          next_data,
	input  logic [EW-1:0]          tail_data,
	output logic [EW-1:0]          data
);

	logic [EW-1:0] data_q;

	// A shift moves every entry one place toward the head; the last active
	// cell takes the tail word instead of its neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctl.clear) begin
			data_q <= '0;
		end else if (ctl.shift) begin
			data_q <= is_last ? tail_data : next_data;
		end else if (ctl.load && is_load) begin
			data_q <= tail_data;
		end
	end

	assign data = data_q;

endmodule

// ===== hdl/ohr_regs.sv =====
// APB-style configuration register file holding the ring depth.
module ohr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ohr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output ohr_pkg::ohr_cfg_t           cfg
);

	logic [ohr_pkg::CNT_W-1:0] ring_depth_q;
	logic                      wr_depth;

	assign wr_depth = psel && penable && pwrite && !paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_depth_q <= ohr_pkg::RING_DEPTH_RST;
		end else if (wr_depth) begin
			ring_depth_q <= pwdata[ohr_pkg::CNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32 - ohr_pkg::CNT_W){1'b0}}, ring_depth_q};
	assign cfg.depth = ring_depth_q;
	assign cfg.clear = wr_depth;

endmodule
